// ===== rtl/core/lpr_pkg.sv =====
// Shared types, sizes and codes for the IPv4 longest-prefix router core.
// Depends on nothing; imported by ipv4_longest_prefix_router_core.
`default_nettype none
package lpr_pkg;

   localparam int MAX_ROUTES     = 32;
   localparam int NUM_INTERFACES = 16;

   localparam int ADDR_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
   localparam int CNT_W  = $clog2(MAX_ROUTES + 1);
   localparam int IP_W   = 32;
   localparam int LEN_W  = 6;
   localparam int ITF_W  = 4;
   localparam int TTL_W  = 8;
   localparam int STAT_W = 3;

   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(IP_W);

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_ROUTE = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_ADDED   = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL    = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_FWD     = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_TTL     = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_NOROUTE = 3'd4;

   typedef struct packed {
      logic [IP_W-1:0]  prefix;
      logic [LEN_W-1:0] len;
   } route_entry_type;

   typedef struct packed {
      logic             has_hop;
      logic [IP_W-1:0]  hop;
      logic [ITF_W-1:0] itf;
   } hop_entry_type;

   // Network mask with the top len bits set; len is at most 32.
   function automatic logic [IP_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      len_mask = ~({IP_W{1'b1}} >> len);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ipv4_longest_prefix_router_core.sv =====
// IPv4 longest-prefix router core: route table memories, scan sequencer and result registers.
// Depends on lpr_pkg for sizes, status codes and the prefix mask function.
`default_nettype none
// Usage:
// A transaction is offered on the req_ ports with start high and is taken at the
// rising edge where busy is low. req_type selects an add (route table append) or a
// route lookup. Every transaction produces exactly one response, shown on the rsp_
// ports for a single cycle with rsp_valid high; the receiver cannot stall it, so it
// must sample at that edge.
// An add, a lookup whose TTL is 0 or 1, and a lookup against an empty table answer
// in the cycle right after acceptance, and busy stays low, so one such transaction
// can be taken every cycle.
// A lookup against a table of n routes walks the table one entry per cycle through
// a single mask-and-compare unit fed by the registered read port of the route
// memory, then reads the forwarding data of the best entry and registers the
// response; busy is high until the response appears, so lookups do not overlap.
// Ties in prefix length go to the later entry; a zero-length prefix matches all.
// A synchronous reset empties the table (the route count returns to zero) and
// aborts any lookup in progress; table contents are not cleared.
module ipv4_longest_prefix_router_core
   import lpr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_type,
   input  wire logic [IP_W-1:0]   req_route_prefix,
   input  wire logic [LEN_W-1:0]  req_prefix_length,
   input  wire logic              req_has_next_hop,
   input  wire logic [IP_W-1:0]   req_next_hop_addr,
   input  wire logic [ITF_W-1:0]  req_interface_index,
   input  wire logic [IP_W-1:0]   req_dest_addr,
   input  wire logic [TTL_W-1:0]  req_ttl_in,
   output logic                   rsp_valid,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [ITF_W-1:0]       rsp_out_interface,
   output logic [IP_W-1:0]        rsp_out_next_hop,
   output logic [TTL_W-1:0]       rsp_ttl_out
);

   // Sequencer states.
   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_SCAN    = 2'd1;
   localparam logic [1:0] S_FETCH   = 2'd2;
   localparam logic [1:0] S_RESOLVE = 2'd3;

   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_ROUTES);

   // Route table: prefix and length are scanned, the forwarding data is read once.
   route_entry_type route_mem [MAX_ROUTES];
   hop_entry_type   hop_mem   [MAX_ROUTES];

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0]   rd_idx_ff, rd_idx_in;
   route_entry_type     rd_entry_ff;
   hop_entry_type       hop_rd_ff;
   logic [IP_W-1:0]     dest_ff, dest_in;
   logic [TTL_W-1:0]    ttl_ff, ttl_in;
   logic                found_ff, found_in;
   logic [ADDR_W-1:0]   best_ff, best_in;
   logic [LEN_W-1:0]    best_len_ff, best_len_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ITF_W-1:0]    rsp_itf_ff, rsp_itf_in;
   logic [IP_W-1:0]     rsp_hop_ff, rsp_hop_in;
   logic [TTL_W-1:0]    rsp_ttl_ff, rsp_ttl_in;

   logic                accept;
   logic                table_full;
   logic                mem_we;
   logic [LEN_W-1:0]    add_len;
   logic                entry_hit;
   logic [IP_W-1:0]     entry_mask;
   logic                last_compare;
   logic                itf_missing;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign table_full = (count_ff == COUNT_MAX);
   assign mem_we     = accept && (req_type == REQ_ADD) && !table_full;
   assign add_len    = (req_prefix_length > LEN_FULL) ? LEN_FULL : req_prefix_length;

   // The shared compare unit: one table entry against the destination per cycle.
   assign entry_mask   = len_mask(rd_entry_ff.len);
   assign entry_hit    = (((dest_ff ^ rd_entry_ff.prefix) & entry_mask) == '0)
                         && (rd_entry_ff.len >= best_len_ff);
   assign last_compare = rd_valid_ff
                         && (CNT_W'(rd_idx_ff) == (count_ff - 1'b1));
   assign itf_missing  = (32'(hop_rd_ff.itf) >= 32'(NUM_INTERFACES));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = rd_idx_ff;
      dest_in       = dest_ff;
      ttl_in        = ttl_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_len_in   = best_len_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_itf_in    = rsp_itf_ff;
      rsp_hop_in    = rsp_hop_ff;
      rsp_ttl_in    = rsp_ttl_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_itf_in = '0;
               rsp_hop_in = '0;
               rsp_ttl_in = '0;
               if (req_type == REQ_ADD) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = table_full ? STATUS_FULL : STATUS_ADDED;
                  if (!table_full) begin
                     count_in = count_ff + 1'b1;
                  end
               end else if (req_ttl_in <= TTL_W'(1)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_TTL;
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NOROUTE;
               end else begin
                  state_in    = S_SCAN;
                  dest_in     = req_dest_addr;
                  ttl_in      = req_ttl_in;
                  issue_in    = '0;
                  found_in    = 1'b0;
                  best_in     = '0;
                  best_len_in = '0;
               end
            end
         end
         S_SCAN: begin
            // Issue side: one read of the route memory per cycle.
            if (issue_ff < count_ff) begin
               rd_valid_in = 1'b1;
               rd_idx_in   = issue_ff[ADDR_W-1:0];
               issue_in    = issue_ff + 1'b1;
            end
            // Compare side: a later hit of equal length replaces the earlier one.
            if (rd_valid_ff && entry_hit) begin
               found_in    = 1'b1;
               best_in     = rd_idx_ff;
               best_len_in = rd_entry_ff.len;
            end
            if (last_compare) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (!found_ff || itf_missing) begin
               rsp_status_in = STATUS_NOROUTE;
               rsp_itf_in    = '0;
               rsp_hop_in    = '0;
               rsp_ttl_in    = '0;
            end else begin
               rsp_status_in = STATUS_FWD;
               rsp_itf_in    = hop_rd_ff.itf;
               rsp_hop_in    = hop_rd_ff.has_hop ? hop_rd_ff.hop : dest_ff;
               rsp_ttl_in    = ttl_ff - 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      issue_ff      <= issue_in;
      rd_idx_ff     <= rd_idx_in;
      dest_ff       <= dest_in;
      ttl_ff        <= ttl_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_len_ff   <= best_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_itf_ff    <= rsp_itf_in;
      rsp_hop_ff    <= rsp_hop_in;
      rsp_ttl_ff    <= rsp_ttl_in;
   end

   // Route memories: one write port at the append address, registered reads.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         route_mem[count_ff[ADDR_W-1:0]] <= '{prefix: req_route_prefix, len: add_len};
         hop_mem[count_ff[ADDR_W-1:0]]   <= '{has_hop: req_has_next_hop,
                                              hop:     req_next_hop_addr,
                                              itf:     req_interface_index};
      end
      rd_entry_ff <= route_mem[issue_ff[ADDR_W-1:0]];
      hop_rd_ff   <= hop_mem[best_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_interface = rsp_itf_ff;
   assign rsp_out_next_hop  = rsp_hop_ff;
   assign rsp_ttl_out       = rsp_ttl_ff;

   // The route count never passes the table size.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("route count above table size");

   // Every accepted transaction either answers next cycle or starts a scan.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || state_ff == S_SCAN))
      else $error("accepted transaction neither answered nor scanning");

   // A forwarded datagram always leaves with a nonzero TTL.
   a_fwd_ttl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_FWD) |-> (rsp_ttl_ff != '0))
      else $error("forwarded datagram with zero TTL");

   // The scan issue pointer stays within the populated part of the table.
   a_issue_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (issue_ff <= count_ff))
      else $error("scan pointer beyond route count");

endmodule
`default_nettype wire
